// File: rtl/core/bss_pkg.sv
// Shared types and constants of the byte signature scanner.
// Depends on nothing; every other file of the block uses it.
package bss_pkg;

    // Sizes of the pattern, the gap and the byte window
    localparam int MAX_PATTERN  = 16;
    localparam int MAX_DISTANCE = 44;
    localparam int WINDOW_DEPTH = 64;

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int PAT_AW = $clog2(MAX_PATTERN);
    localparam int DIST_W = 6;
    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int OLD_W  = WIN_AW + 1;
    localparam int WAIT_W = DIST_W + 1;

    localparam logic [31:0] RESET_BASE = 32'h0040_0000;
    localparam logic [31:0] CALL_LEN   = 32'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] CFG_PATTERN_LEN  = 3'd2;
    localparam logic [2:0] CFG_DISTANCE     = 3'd3;
    localparam logic [2:0] CFG_FIND_MODE    = 3'd4;
    localparam logic [2:0] CFG_SCAN_BASE    = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_scan;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word_value;
        logic [31:0] match_address;
        logic [31:0] call_target;
    } t_out_item;

    // Configuration after clamping, as the datapath uses it
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pattern;
        logic [LEN_W-1:0]            len;
        logic [DIST_W-1:0]           distance;
        logic                        mode;
        logic [31:0]                 base;
        logic [OLD_W-1:0]            oldest;
    } t_cfg;

    // Window compare results handed to the scan control
    typedef struct packed {
        logic        hit;
        logic [31:0] word_before;
        logic [31:0] word_after;
    } t_win_info;

endpackage

// File: rtl/core/bss_window.sv
// Byte window shift line with the parallel pattern compare and word taps.
// Depends on bss_pkg.
module bss_window (
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic [7:0]         i_byte,
    input  bss_pkg::t_cfg      i_cfg,
    output bss_pkg::t_win_info o_info
);

    logic [bss_pkg::WINDOW_DEPTH-1:0][7:0] r_window;
    logic [bss_pkg::WINDOW_DEPTH-1:0][7:0] n_window;

    // Newest byte at age 0
    assign n_window = {r_window[bss_pkg::WINDOW_DEPTH-2:0], i_byte};

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_window <= n_window;
        end
    end

    // Pattern byte k must sit at age len-1-k; word before the match has
    // byte i at age oldest-i, word after it byte i at age 3-i
    always_comb begin : win_cmp
        logic                       hit;
        logic [bss_pkg::LEN_W-1:0]  age;
        logic [bss_pkg::WIN_AW-1:0] pos;
        logic [bss_pkg::WIN_AW-1:0] idx;
        hit = 1'b1;
        age = '0;
        pos = '0;
        idx = '0;
        for (int k = 0; k < bss_pkg::MAX_PATTERN; k++) begin
            if (bss_pkg::LEN_W'(k) < i_cfg.len) begin
                age = i_cfg.len - bss_pkg::LEN_W'(1) - bss_pkg::LEN_W'(k);
                pos = bss_pkg::WIN_AW'(age[bss_pkg::PAT_AW-1:0]);
                if (n_window[pos] != i_cfg.pattern[k]) begin
                    hit = 1'b0;
                end
            end
        end
        o_info.hit = hit;
        for (int i = 0; i < 4; i++) begin
            idx = i_cfg.oldest[bss_pkg::WIN_AW-1:0] - bss_pkg::WIN_AW'(i);
            o_info.word_before[8*i +: 8] = n_window[idx];
            o_info.word_after[8*i +: 8]  = n_window[bss_pkg::WIN_AW'(3-i)];
        end
    end

endmodule

// File: rtl/core/bss_scan.sv
// Scan control: byte count, pending mode 1 match and result forming.
// Depends on bss_pkg.
module bss_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic                      i_eos,
    input  bss_pkg::t_cfg             i_cfg,
    input  bss_pkg::t_win_info        i_info,
    output logic                      o_shift,
    output logic                      o_res_valid,
    output bss_pkg::t_out_item        o_res
);

    logic [31:0]                r_count,     n_count;
    logic                       r_pending,   n_pending;
    logic [bss_pkg::WAIT_W-1:0] r_wait,      n_wait;
    logic [31:0]                r_held_addr, n_held_addr;
    logic [bss_pkg::DIST_W-1:0] r_held_dist, n_held_dist;
    logic                       r_done,      n_done;

    logic [31:0]                cnt_inc;
    logic [bss_pkg::WAIT_W-1:0] wait_dec;
    logic [bss_pkg::WAIT_W-1:0] gap;
    logic [31:0]                start;
    logic [31:0]                addr_m0;
    logic [31:0]                addr_m1;
    logic [31:0]                call_m0;
    logic [31:0]                call_m1;

    // Datapath terms for the current item
    assign cnt_inc  = (r_count == '1) ? r_count : r_count + 32'd1;
    assign wait_dec = (r_wait != '0) ? r_wait - bss_pkg::WAIT_W'(1) : r_wait;
    assign gap      = bss_pkg::WAIT_W'(i_cfg.distance) + bss_pkg::WAIT_W'(4);
    assign start    = r_count - (32'(i_cfg.len) - 32'd1);
    assign addr_m0  = i_cfg.base + start;
    assign addr_m1  = i_cfg.base + r_count;
    assign call_m0  = i_info.word_before + addr_m0 - 32'(i_cfg.distance);
    assign call_m1  = i_info.word_after + r_held_addr + bss_pkg::CALL_LEN
                      + 32'(r_held_dist);

    assign o_shift = i_go && !r_done;

    // Next state and result of one item
    always_comb begin
        n_count     = r_count;
        n_pending   = r_pending;
        n_wait      = r_wait;
        n_held_addr = r_held_addr;
        n_held_dist = r_held_dist;
        n_done      = r_done;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_go && !r_done) begin
            n_count = cnt_inc;
            if (r_pending) begin
                n_wait = wait_dec;
                if (wait_dec == '0) begin
                    o_res_valid         = 1'b1;
                    o_res.status        = bss_pkg::ST_FOUND;
                    o_res.word_value    = i_info.word_after;
                    o_res.match_address = r_held_addr;
                    o_res.call_target   = call_m1;
                end else if (i_eos) begin
                    o_res_valid         = 1'b1;
                    o_res.status        = bss_pkg::ST_OUTSIDE;
                    o_res.match_address = r_held_addr;
                end
            end else if (cnt_inc >= 32'(i_cfg.len) && i_info.hit) begin
                if (!i_cfg.mode) begin
                    o_res_valid         = 1'b1;
                    o_res.match_address = addr_m0;
                    if (start < 32'(gap) ||
                        32'(i_cfg.oldest) >= 32'(bss_pkg::WINDOW_DEPTH)) begin
                        o_res.status = bss_pkg::ST_OUTSIDE;
                    end else begin
                        o_res.status      = bss_pkg::ST_FOUND;
                        o_res.word_value  = i_info.word_before;
                        o_res.call_target = call_m0;
                    end
                end else if (i_eos || 32'(gap) > 32'(bss_pkg::WINDOW_DEPTH)) begin
                    o_res_valid         = 1'b1;
                    o_res.status        = bss_pkg::ST_OUTSIDE;
                    o_res.match_address = addr_m1;
                end else begin
                    n_pending   = 1'b1;
                    n_wait      = gap;
                    n_held_addr = addr_m1;
                    n_held_dist = i_cfg.distance;
                end
            end
            if (!o_res_valid && i_eos) begin
                o_res_valid  = 1'b1;
                o_res.status = bss_pkg::ST_NO_MATCH;
            end
            if (!i_eos && o_res_valid) begin
                n_done    = 1'b1;
                n_pending = 1'b0;
                n_wait    = '0;
            end
        end
        // End of scan starts a fresh scan
        if (i_go && i_eos) begin
            n_count     = '0;
            n_pending   = 1'b0;
            n_wait      = '0;
            n_held_addr = '0;
            n_held_dist = '0;
            n_done      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_wait      <= '0;
            r_held_addr <= '0;
            r_held_dist <= '0;
            r_done      <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_wait      <= n_wait;
            r_held_addr <= n_held_addr;
            r_held_dist <= n_held_dist;
            r_done      <= n_done;
        end
    end

    // A finished scan never holds a pending match
    a_pend_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending && r_done))
        else $error("pending match in a finished scan");

    // A pending match always waits for at least one byte
    a_pend_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_wait != '0))
        else $error("pending match with nothing to wait for");

    // No result without an item being processed
    a_res_go : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_go && !r_done))
        else $error("result without a processed item");

    // A result inside a scan closes it until end of scan
    a_res_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_eos) |=> r_done)
        else $error("scan not closed after result");

endmodule

// File: rtl/core/byte_signature_scanner.sv
// Byte signature scanner: one byte per cycle while not stalled, exact pattern
// match, word fetch; results leave through the result register.
// Throughput: one item per cycle while the output does not stall; pattern
// compare and word taps sit in one stage between the input and result registers.
// Reset (i_rst_n low, synchronous): scan state cleared, registers to defaults.
// Depends on bss_pkg, bss_window and bss_scan.
module byte_signature_scanner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bss_pkg::t_in_item   i_in_data,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bss_pkg::t_out_item  o_out_data,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    logic [63:0]                r_pat_lo;
    logic [63:0]                r_pat_hi;
    logic [4:0]                 r_pat_len;
    logic [bss_pkg::DIST_W-1:0] r_dist;
    logic                       r_mode;
    logic [31:0]                r_base;

    logic                       r_in_valid;
    bss_pkg::t_in_item          r_in;
    logic                       r_out_valid;
    bss_pkg::t_out_item         r_out;

    bss_pkg::t_cfg              cfg;
    bss_pkg::t_win_info         win_info;
    logic                       go;
    logic                       in_take;
    logic                       shift;
    logic                       res_valid;
    bss_pkg::t_out_item         res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= 5'd1;
            r_dist    <= bss_pkg::DIST_W'(1);
            r_mode    <= 1'b1;
            r_base    <= bss_pkg::RESET_BASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bss_pkg::CFG_PATTERN_LOW:  r_pat_lo  <= i_cfg_data;
                bss_pkg::CFG_PATTERN_HIGH: r_pat_hi  <= i_cfg_data;
                bss_pkg::CFG_PATTERN_LEN:  r_pat_len <= i_cfg_data[4:0];
                bss_pkg::CFG_DISTANCE:     r_dist    <= i_cfg_data[bss_pkg::DIST_W-1:0];
                bss_pkg::CFG_FIND_MODE:    r_mode    <= i_cfg_data[0];
                bss_pkg::CFG_SCAN_BASE:    r_base    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Clamp length and gap, derive the age of the oldest word byte
    always_comb begin
        cfg.pattern = {r_pat_hi, r_pat_lo};
        if (r_pat_len == '0) begin
            cfg.len = bss_pkg::LEN_W'(1);
        end else if (32'(r_pat_len) > 32'(bss_pkg::MAX_PATTERN)) begin
            cfg.len = bss_pkg::LEN_W'(bss_pkg::MAX_PATTERN);
        end else begin
            cfg.len = bss_pkg::LEN_W'(r_pat_len);
        end
        if (32'(r_dist) > 32'(bss_pkg::MAX_DISTANCE)) begin
            cfg.distance = bss_pkg::DIST_W'(bss_pkg::MAX_DISTANCE);
        end else begin
            cfg.distance = r_dist;
        end
        cfg.mode   = r_mode;
        cfg.base   = r_base;
        cfg.oldest = bss_pkg::OLD_W'(cfg.len) - bss_pkg::OLD_W'(1)
                     + bss_pkg::OLD_W'(cfg.distance) + bss_pkg::OLD_W'(4);
    end

    // Handshake: the held item is processed when the result register can take it
    assign go         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !go;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    bss_window u_window (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_byte  (r_in.data_byte),
        .i_cfg   (cfg),
        .o_info  (win_info)
    );

    bss_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_eos       (r_in.end_of_scan),
        .i_cfg       (cfg),
        .i_info      (win_info),
        .o_shift     (shift),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
